// ----- rtl/core/dlr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants for the dense layer / ReLU core.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Q8.8 operand width and result width (result is unsigned Q7.8)
    localparam int VALUE_BITS = 16;
    localparam int ACT_BITS   = 15;
    localparam logic [ACT_BITS-1:0] ACT_MAX = '1;

    // register file
    localparam int IN_CNT_BITS  = 11;
    localparam int OUT_CNT_BITS = 7;
    localparam logic [IN_CNT_BITS-1:0]  INPUTS_RESET  = 11'd1024;
    localparam logic [OUT_CNT_BITS-1:0] OUTPUTS_RESET = 7'd64;
    localparam logic REG_INPUTS  = 1'b0;
    localparam logic REG_OUTPUTS = 1'b1;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_INPUT  = 2'd2,
        CMD_RUN    = 2'd3
    } t_cmd;

    // sequencer -> MAC control
    typedef struct packed {
        logic load_bias;   // bias RAM output valid this cycle
        logic rd_valid;    // input/weight RAM outputs valid this cycle
    } t_mac_ctl;

endpackage

// ----- rtl/core/dlr_ram.sv -----
// ----------------------------------------------------------------------------
// dlr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dlr_mac.sv -----
// ----------------------------------------------------------------------------
// dlr_mac
// Shared multiply-accumulate unit with ReLU, shift and saturation on output.
// ----------------------------------------------------------------------------
module dlr_mac #(
    parameter int ACC_W = 43
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dlr_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [dlr_pkg::VALUE_BITS-1:0]  i_bias,
    input  logic signed [dlr_pkg::VALUE_BITS-1:0]  i_data,
    input  logic signed [dlr_pkg::VALUE_BITS-1:0]  i_weight,
    output logic                                   o_busy,
    output logic [dlr_pkg::ACT_BITS-1:0]           o_activation
);

    localparam int VB = dlr_pkg::VALUE_BITS;
    localparam int PW = 2 * VB;
    localparam int FRAC = 8;

    logic signed [PW-1:0]    r_prod;
    logic                    r_prod_v;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.rd_valid;
        end
    end

    // product stage, then accumulate; bias load is Q8.8 -> Q16.16
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_valid) begin
            r_prod <= i_data * i_weight;
        end
        if (i_ctl.load_bias) begin
            r_acc <= {{(ACC_W-VB-FRAC){i_bias[VB-1]}}, i_bias, {FRAC{1'b0}}};
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_prod_v;

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            o_activation = '0;
        end else if (|r_acc[ACC_W-2:FRAC+dlr_pkg::ACT_BITS]) begin
            o_activation = dlr_pkg::ACT_MAX;
        end else begin
            o_activation = r_acc[FRAC+dlr_pkg::ACT_BITS-1:FRAC];
        end
    end

endmodule

// ----- rtl/core/dense_layer_relu_core.sv -----
// ----------------------------------------------------------------------------
// dense_layer_relu_core
// Fully connected layer with ReLU over stored weights, biases and inputs.
// ----------------------------------------------------------------------------
// Load commands (weight, bias, input) keep busy low.
// A run issues one MAC per input element plus a bias fetch and a pipeline
// drain per neuron, all through the single shared multiply-accumulate unit.
// Results strobe one per neuron, the last in the first cycle that busy is low;
// the receiver cannot stall.
// Synchronous active-low reset clears control and config; RAMs are not cleared.
module dense_layer_relu_core #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_command,
    input  logic [5:0]                            i_output_index,
    input  logic [9:0]                            i_input_index,
    input  logic signed [dlr_pkg::VALUE_BITS-1:0] i_value,
    // results
    output logic                                  o_result_valid,
    output logic [5:0]                            o_neuron_index,
    output logic [dlr_pkg::ACT_BITS-1:0]          o_activation,
    output logic                                  o_last_output,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int VB    = dlr_pkg::VALUE_BITS;
    localparam int IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int WD    = MAX_INPUTS * MAX_OUTPUTS;
    localparam int WAW   = (WD > 1) ? $clog2(WD) : 1;
    localparam int ACC_W = 2 * VB + $clog2(MAX_INPUTS) + 1;
    localparam int ICW   = ($clog2(MAX_INPUTS + 1) > dlr_pkg::IN_CNT_BITS) ?
                           $clog2(MAX_INPUTS + 1) : dlr_pkg::IN_CNT_BITS;
    localparam int OCW   = dlr_pkg::OUT_CNT_BITS;
    localparam logic [ICW-1:0] IN_LIM  = ICW'(MAX_INPUTS);
    localparam logic [OCW-1:0] OUT_LIM = OCW'(MAX_OUTPUTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN
    } t_state;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [dlr_pkg::IN_CNT_BITS-1:0]  r_inputs_in_use;
    logic [dlr_pkg::OUT_CNT_BITS-1:0] r_outputs_in_use;
    logic                             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_in_use  <= dlr_pkg::INPUTS_RESET;
            r_outputs_in_use <= dlr_pkg::OUTPUTS_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                dlr_pkg::REG_INPUTS:  r_inputs_in_use  <= pwdata[dlr_pkg::IN_CNT_BITS-1:0];
                dlr_pkg::REG_OUTPUTS: r_outputs_in_use <= pwdata[dlr_pkg::OUT_CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dlr_pkg::REG_INPUTS:  prdata = 32'(r_inputs_in_use);
            dlr_pkg::REG_OUTPUTS: prdata = 32'(r_outputs_in_use);
            default:              prdata = '0;
        endcase
    end

    // effective counts: zero acts as one, clipped to the store sizes
    logic [ICW-1:0] w_n_in;
    logic [OCW-1:0] w_n_out;

    always_comb begin
        if (r_inputs_in_use == '0) begin
            w_n_in = ICW'(1);
        end else if (ICW'(r_inputs_in_use) > IN_LIM) begin
            w_n_in = IN_LIM;
        end else begin
            w_n_in = ICW'(r_inputs_in_use);
        end
        if (r_outputs_in_use == '0) begin
            w_n_out = OCW'(1);
        end else if (r_outputs_in_use > OUT_LIM) begin
            w_n_out = OUT_LIM;
        end else begin
            w_n_out = r_outputs_in_use;
        end
    end

    // ------------------------------------------------------------------
    // Load path
    // ------------------------------------------------------------------
    t_state r_state;
    logic   w_accept;
    logic   w_oi_ok;
    logic   w_ii_ok;
    logic   w_we_weight;
    logic   w_we_bias;
    logic   w_we_input;
    logic [WAW-1:0] w_load_waddr;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_oi_ok  = (OCW'(i_output_index) < OUT_LIM);
    assign w_ii_ok  = (ICW'(i_input_index) < IN_LIM);

    assign w_we_weight = w_accept && (i_command == dlr_pkg::CMD_WEIGHT) && w_oi_ok && w_ii_ok;
    assign w_we_bias   = w_accept && (i_command == dlr_pkg::CMD_BIAS) && w_oi_ok;
    assign w_we_input  = w_accept && (i_command == dlr_pkg::CMD_INPUT) && w_ii_ok;
    assign w_load_waddr = WAW'(i_output_index) * WAW'(MAX_INPUTS) + WAW'(i_input_index);

    // ------------------------------------------------------------------
    // Run sequencer
    // ------------------------------------------------------------------
    logic [IW-1:0]  r_in_idx;
    logic [IW-1:0]  r_in_last;
    logic [OW-1:0]  r_out_idx;
    logic [OW-1:0]  r_out_last;
    logic [WAW-1:0] r_waddr;
    logic [WAW-1:0] r_wbase;
    logic           r_rd_v;
    logic           r_bias_v;
    logic           r_result_valid;
    logic [5:0]     r_neuron_index;
    logic [dlr_pkg::ACT_BITS-1:0] r_activation;
    logic           r_last_output;

    logic                         w_mac_busy;
    logic [dlr_pkg::ACT_BITS-1:0] w_mac_act;
    dlr_pkg::t_mac_ctl            w_mac_ctl;
    logic                         w_drain_done;

    // wait until the last product has been accumulated
    assign w_drain_done = (r_state == ST_DRAIN) && !r_rd_v && !w_mac_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_rd_v         <= 1'b0;
            r_bias_v       <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_rd_v         <= (r_state == ST_MAC);
            r_bias_v       <= (r_state == ST_BIAS);
            r_result_valid <= w_drain_done;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_command == dlr_pkg::CMD_RUN)) begin
                        r_in_last  <= IW'(w_n_in - ICW'(1));
                        r_out_last <= OW'(w_n_out - OCW'(1));
                        r_out_idx  <= '0;
                        r_wbase    <= '0;
                        r_state    <= ST_BIAS;
                    end
                end
                ST_BIAS: begin
                    r_in_idx <= '0;
                    r_waddr  <= r_wbase;
                    r_state  <= ST_MAC;
                end
                ST_MAC: begin
                    r_in_idx <= r_in_idx + IW'(1);
                    r_waddr  <= r_waddr + WAW'(1);
                    if (r_in_idx == r_in_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_drain_done) begin
                        r_neuron_index <= 6'(r_out_idx);
                        r_activation   <= w_mac_act;
                        r_last_output  <= (r_out_idx == r_out_last);
                        r_out_idx      <= r_out_idx + OW'(1);
                        r_wbase        <= r_wbase + WAW'(MAX_INPUTS);
                        r_state        <= (r_out_idx == r_out_last) ? ST_IDLE : ST_BIAS;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_neuron_index = r_neuron_index;
    assign o_activation   = r_activation;
    assign o_last_output  = r_last_output;

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    logic [VB-1:0] w_weight_q;
    logic [VB-1:0] w_bias_q;
    logic [VB-1:0] w_input_q;

    dlr_ram #(.WIDTH(VB), .DEPTH(WD)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_weight),
        .i_waddr (w_load_waddr),
        .i_wdata (i_value),
        .i_re    (r_state == ST_MAC),
        .i_raddr (r_waddr),
        .o_rdata (w_weight_q)
    );

    dlr_ram #(.WIDTH(VB), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_bias),
        .i_waddr (OW'(i_output_index)),
        .i_wdata (i_value),
        .i_re    (r_state == ST_BIAS),
        .i_raddr (r_out_idx),
        .o_rdata (w_bias_q)
    );

    dlr_ram #(.WIDTH(VB), .DEPTH(MAX_INPUTS)) u_input_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_input),
        .i_waddr (IW'(i_input_index)),
        .i_wdata (i_value),
        .i_re    (r_state == ST_MAC),
        .i_raddr (r_in_idx),
        .o_rdata (w_input_q)
    );

    // ------------------------------------------------------------------
    // Shared MAC
    // ------------------------------------------------------------------
    assign w_mac_ctl.load_bias = r_bias_v;
    assign w_mac_ctl.rd_valid  = r_rd_v;

    dlr_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_mac_ctl),
        .i_bias       ($signed(w_bias_q)),
        .i_data       ($signed(w_input_q)),
        .i_weight     ($signed(w_weight_q)),
        .o_busy       (w_mac_busy),
        .o_activation (w_mac_act)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_rd_v && !r_bias_v && !w_mac_busy))
        else $error("MAC pipeline active while idle");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> ($past(r_state) == ST_DRAIN))
        else $error("result strobe not issued from drain");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_output) |-> !busy)
        else $error("last result while run still busy");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == dlr_pkg::CMD_RUN)) |=> busy)
        else $error("run request did not raise busy");

endmodule
